>>> hw/rtl/lse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lse_pkg
// Shared constants and types of the linear spline evaluator.
// ----------------------------------------------------------------------------
package lse_pkg;

	localparam int COORD_W = 32;
	localparam int IDX_W   = 6;
	localparam int T_W     = 18;
	localparam int FRAC_W  = 17;
	localparam int COUNT_W = 7;
	localparam int Q16_SH  = 16;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int PROD_W  = DIFF_W + FRAC_W + 1;

	localparam logic [FRAC_W-1:0] Q16_ONE  = FRAC_W'(1 << Q16_SH);
	localparam logic [FRAC_W-1:0] Q16_ZERO = '0;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_EVAL  = 1'b1;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_RANGE = 1'b1;

	typedef struct packed {
		logic ld4;
		logic ld5;
		logic ld6;
		logic zero6;
	} lse_lerp_ctrl_t;

endpackage

>>> hw/rtl/lse_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lse_store
// Knot memory: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module lse_store import lse_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  logic [2*COORD_W-1:0] wdata,
	input  logic                 re,
	input  logic [AW-1:0]        raddr_a,
	input  logic [AW-1:0]        raddr_b,
	output logic [2*COORD_W-1:0] rdata_a,
	output logic [2*COORD_W-1:0] rdata_b
);

	logic [2*COORD_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

>>> hw/rtl/lse_lerp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lse_lerp
// Three-stage interpolation of one coordinate: difference, product, sum.
// ----------------------------------------------------------------------------
module lse_lerp import lse_pkg::*; (
	input  logic                      clk,
	input  lse_lerp_ctrl_t            ctrl,
	input  logic signed [COORD_W-1:0] lo,
	input  logic signed [COORD_W-1:0] hi,
	input  logic [FRAC_W-1:0]         frac,
	output logic [COORD_W-1:0]        result
);

	logic signed [DIFF_W-1:0]  diff_s4;
	logic signed [COORD_W-1:0] lo_s4;
	logic [FRAC_W-1:0]         frac_s4;
	logic signed [PROD_W-1:0]  prod_s5;
	logic signed [COORD_W-1:0] lo_s5;
	logic [COORD_W-1:0]        res_s6;
	logic [COORD_W-1:0]        sum;

	always_ff @(posedge clk) begin
		if (ctrl.ld4) begin
			diff_s4 <= DIFF_W'(hi) - DIFF_W'(lo);
			lo_s4   <= lo;
			frac_s4 <= frac;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ld5) begin
			prod_s5 <= PROD_W'(diff_s4) * PROD_W'(signed'({1'b0, frac_s4}));
			lo_s5   <= lo_s4;
		end
	end

	// floor of the Q16 product: arithmetic shift, then wrap to 32 bits
	assign sum = COORD_W'(lo_s5) + prod_s5[Q16_SH +: COORD_W];

	always_ff @(posedge clk) begin
		if (ctrl.ld6) begin
			res_s6 <= ctrl.zero6 ? '0 : sum;
		end
	end

	assign result = res_s6;

endmodule

>>> hw/rtl/linear_spline_evaluator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_spline_evaluator_core
// Piecewise linear spline over uniformly spaced 2-D knots, six-stage pipeline.
//
//  channel  dir  handshake          payload
//  s_axis   in   tvalid / tready    tdata: knot_index, knot_x, knot_y, param_t
//                                   tuser: mode
//  m_axis   out  tvalid / tready    tdata: out_x, out_y   tuser: status
//  cfg      in   cfg_we             cfg_wdata: knot_count
//
// One transaction per cycle sustained while m_axis_tready stays high; an
// evaluate transaction is presented on m_axis once it has passed every
// stage, a knot write leaves after the memory stage.
// Latency is set by the product stage, the registered knot read and the
// three-stage interpolation. Each stage holds while the one after it is full
// and stalled, so bubbles close up and s_axis_tready stays high until every
// stage is full and m_axis stalls. Reset clears all valid bits and sets
// knot_count to one; knot memory is not cleared.
// ----------------------------------------------------------------------------
module linear_spline_evaluator_core import lse_pkg::*; #(
	parameter int MAX_KNOTS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [COUNT_W-1:0] cfg_wdata,      // knot_count
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [87:0]        s_axis_tdata,   // knot_index, knot_x, knot_y, param_t
	input  logic               s_axis_tuser,   // mode
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [63:0]        m_axis_tdata,   // out_x, out_y
	output logic               m_axis_tuser    // status
);

	localparam int KW = (MAX_KNOTS > 2) ? $clog2(MAX_KNOTS) : 1;
	localparam int SW = FRAC_W + KW;

	logic [KW-1:0] nm1_q;
	logic [31:0]   cnt_ext;
	logic [31:0]   n_clamp;

	// stage valids and readies
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

	// stage 1
	logic               wr_s1, err_s1, st_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic [COORD_W-1:0] kx_s1, ky_s1;
	logic [FRAC_W-1:0]  t_s1;

	// stage 2
	logic               wr_s2, err_s2, st_s2;
	logic [IDX_W-1:0]   idx_s2;
	logic [COORD_W-1:0] kx_s2, ky_s2;
	logic [SW-1:0]      s_s2;

	// stage 3 and beyond
	logic              err_s3, err_s4, err_s5, err_s6;
	logic [FRAC_W-1:0] f_s3;

	logic [T_W-1:0]    in_t;
	logic              in_err;
	logic [KW:0]       seg_raw;
	logic              seg_clamp;
	logic [KW-1:0]     seg_a, seg_b;
	logic [FRAC_W-1:0] frac_n;
	logic              mem_we, mem_re;
	logic [2*COORD_W-1:0] rd_a, rd_b;
	lse_lerp_ctrl_t    lctrl;
	logic [COORD_W-1:0] res_x, res_y;

	// knot count, held as count minus one clamped to the store
	assign cnt_ext = 32'(cfg_wdata);
	always_comb begin
		if (cnt_ext == 32'd0) begin
			n_clamp = 32'd1;
		end else if (cnt_ext > 32'(MAX_KNOTS)) begin
			n_clamp = 32'(MAX_KNOTS);
		end else begin
			n_clamp = cnt_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nm1_q <= '0;
		end else if (cfg_we) begin
			nm1_q <= KW'(n_clamp - 32'd1);
		end
	end

	// handshake chain
	assign rdy6 = !v_s6 || m_axis_tready;
	assign rdy5 = !v_s5 || rdy6;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign s_axis_tready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_axis_tvalid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2 && !wr_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
			if (rdy6) v_s6 <= v_s5;
		end
	end

	// stage 1: capture, domain check
	assign in_t   = s_axis_tdata[87:70];
	assign in_err = in_t[T_W-1] || (in_t[Q16_SH] && (|in_t[Q16_SH-1:0]));

	always_ff @(posedge clk) begin
		if (rdy1 && s_axis_tvalid) begin
			wr_s1  <= (s_axis_tuser == MODE_WRITE);
			err_s1 <= in_err;
			st_s1  <= (nm1_q == '0);
			idx_s1 <= s_axis_tdata[5:0];
			kx_s1  <= s_axis_tdata[37:6];
			ky_s1  <= s_axis_tdata[69:38];
			t_s1   <= in_t[FRAC_W-1:0];
		end
	end

	// stage 2: s = t * (n - 1)
	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			wr_s2  <= wr_s1;
			err_s2 <= err_s1;
			st_s2  <= st_s1;
			idx_s2 <= idx_s1;
			kx_s2  <= kx_s1;
			ky_s2  <= ky_s1;
			s_s2   <= SW'(t_s1) * SW'(nm1_q);
		end
	end

	// stage 3: segment, fraction, knot read or knot write
	assign seg_raw   = s_s2[SW-1:Q16_SH];
	assign seg_clamp = (seg_raw >= {1'b0, nm1_q});

	always_comb begin
		if (st_s2) begin
			seg_a  = '0;
			seg_b  = '0;
			frac_n = Q16_ZERO;
		end else if (seg_clamp) begin
			seg_a  = nm1_q - KW'(1);
			seg_b  = nm1_q;
			frac_n = Q16_ONE;
		end else begin
			seg_a  = seg_raw[KW-1:0];
			seg_b  = seg_raw[KW-1:0] + KW'(1);
			frac_n = {1'b0, s_s2[Q16_SH-1:0]};
		end
	end

	assign mem_we = rdy3 && v_s2 && wr_s2 && (32'(idx_s2) < 32'(MAX_KNOTS));
	assign mem_re = rdy3 && v_s2 && !wr_s2;

	lse_store #(
		.DEPTH (MAX_KNOTS),
		.AW    (KW)
	) u_store (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (KW'(idx_s2)),
		.wdata   ({ky_s2, kx_s2}),
		.re      (mem_re),
		.raddr_a (seg_a),
		.raddr_b (seg_b),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	always_ff @(posedge clk) begin
		if (mem_re) begin
			err_s3 <= err_s2;
			f_s3   <= frac_n;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) err_s4 <= err_s3;
		if (rdy5 && v_s4) err_s5 <= err_s4;
		if (rdy6 && v_s5) err_s6 <= err_s5;
	end

	// stages 4 to 6: interpolation
	assign lctrl.ld4   = rdy4 && v_s3;
	assign lctrl.ld5   = rdy5 && v_s4;
	assign lctrl.ld6   = rdy6 && v_s5;
	assign lctrl.zero6 = err_s5;

	lse_lerp u_lerp_x (
		.clk    (clk),
		.ctrl   (lctrl),
		.lo     (rd_a[COORD_W-1:0]),
		.hi     (rd_b[COORD_W-1:0]),
		.frac   (f_s3),
		.result (res_x)
	);

	lse_lerp u_lerp_y (
		.clk    (clk),
		.ctrl   (lctrl),
		.lo     (rd_a[2*COORD_W-1:COORD_W]),
		.hi     (rd_b[2*COORD_W-1:COORD_W]),
		.frac   (f_s3),
		.result (res_y)
	);

	assign m_axis_tvalid = v_s6;
	assign m_axis_tdata  = {res_y, res_x};
	assign m_axis_tuser  = err_s6 ? STATUS_RANGE : STATUS_OK;

	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser == STATUS_RANGE)) |-> (m_axis_tdata == '0))
		else $error("out-of-domain result carries nonzero coordinates");

	a_seg_adjacent: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_re && !st_s2) |-> (seg_b == seg_a + KW'(1)))
		else $error("knot reads are not adjacent");

	a_frac_bound: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |-> (frac_n <= Q16_ONE))
		else $error("fraction above one");

	a_no_write_out: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && wr_s2 && rdy3) |=> !v_s3)
		else $error("knot write entered the interpolation stages");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the linear spline evaluator core. It loads the whole
// knot store first, so that every evaluation reads written knots. It then
// runs a short directed set: domain edges, extreme coordinates and a write
// followed at once by a read. After that come random phases over knot counts
// that include 0, 1, 2, 64, 65 and 127, under changing backpressure. Expected
// points are computed by an in-bench model and matched in order.
// ----------------------------------------------------------------------------
module tb import lse_pkg::*; ();

	localparam int KNOTS   = 64;
	localparam int PHASES  = 12;
	localparam int PER_PHASE = 100;
	localparam int SETTLE  = 10;

	typedef struct {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               status;
	} spline_point_t;

	class spline_checker;
		logic [COORD_W-1:0] knot_xs [KNOTS];
		logic [COORD_W-1:0] knot_ys [KNOTS];
		logic [COUNT_W-1:0] knot_count;
		spline_point_t      expected_points [$];
		int                 failures;
		int                 reported;
		int                 points_checked;
		int                 evals;
		int                 writes;
		int                 out_of_domain;

		function new();
			knot_count     = 1;
			failures       = 0;
			reported       = 0;
			points_checked = 0;
			evals          = 0;
			writes         = 0;
			out_of_domain  = 0;
		endfunction

		function void set_count(logic [COUNT_W-1:0] v);
			knot_count = v;
		endfunction

		function int pending();
			return expected_points.size();
		endfunction

		function logic [COORD_W-1:0] blend(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b,
			longint f);
			longint lo;
			longint hi;
			longint r;
			lo = longint'($signed(a));
			hi = longint'($signed(b));
			r = lo + (((hi - lo) * f) >>> Q16_SH);
			return r[COORD_W-1:0];
		endfunction

		function void record_transaction(logic mode, logic [IDX_W-1:0] idx,
			logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, logic [T_W-1:0] t);
			longint        tv;
			longint        s;
			longint        f;
			longint        one;
			int            n;
			int            k;
			spline_point_t e;
			one = longint'(Q16_ONE);
			if (mode == MODE_WRITE) begin
				knot_xs[idx] = x;
				knot_ys[idx] = y;
				writes++;
				return;
			end
			evals++;
			tv = longint'($signed(t));
			if (tv < 0 || tv > one) begin
				e.x = '0;
				e.y = '0;
				e.status = STATUS_RANGE;
				out_of_domain++;
			end else begin
				n = int'(knot_count);
				if (n < 1) n = 1;
				if (n > KNOTS) n = KNOTS;
				e.status = STATUS_OK;
				if (n == 1) begin
					e.x = knot_xs[0];
					e.y = knot_ys[0];
				end else begin
					s = tv * longint'(n - 1);
					k = int'(s / one);
					if (k > n - 2) k = n - 2;
					f = s - longint'(k) * one;
					e.x = blend(knot_xs[k], knot_xs[k+1], f);
					e.y = blend(knot_ys[k], knot_ys[k+1], f);
				end
			end
			expected_points.insert(expected_points.size(), e);
		endfunction

		function void check_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
			logic status);
			spline_point_t e;
			if (expected_points.size() == 0) begin
				failures++;
				if (reported < 10) begin
					reported++;
					$display("[%0t] unexpected point x=%h y=%h status=%b",
						$time, x, y, status);
				end
				return;
			end
			e = expected_points.pop_front();
			points_checked++;
			if (x !== e.x || y !== e.y || status !== e.status) begin
				failures++;
				if (reported < 10) begin
					reported++;
					$display("[%0t] point mismatch: expected x=%h y=%h status=%b,",
						$time, e.x, e.y, e.status);
					$display("    got x=%h y=%h status=%b", x, y, status);
				end
			end
		endfunction

		function void close();
			if (expected_points.size() != 0) begin
				failures += expected_points.size();
				$display("%0d expected points never arrived", expected_points.size());
			end
		endfunction
	endclass

	logic               clk            = 1'b0;
	logic               arst_n         = 1'b0;
	logic               cfg_we         = 1'b0;
	logic [COUNT_W-1:0] cfg_wdata      = '0;
	logic               s_axis_tvalid  = 1'b0;
	logic               s_axis_tready;
	logic [87:0]        s_axis_tdata   = '0;
	logic               s_axis_tuser   = MODE_WRITE;
	logic               m_axis_tvalid;
	logic               m_axis_tready  = 1'b0;
	logic [63:0]        m_axis_tdata;
	logic               m_axis_tuser;

	int                 src_idle_pct   = 27;
	int                 sink_idle_pct  = 48;
	int                 cfg_writes     = 0;
	spline_checker      curve          = new();

	linear_spline_evaluator_core #(
		.MAX_KNOTS(KNOTS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(negedge clk) begin
		m_axis_tready = ($urandom_range(99) >= sink_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			curve.check_point(m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser);
	end

	task automatic send_item(input logic mode, input logic [IDX_W-1:0] idx,
		input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y, input logic [T_W-1:0] t);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = {t, y, x, idx};
		s_axis_tuser  = mode;
		do @(posedge clk); while (!s_axis_tready);
		curve.record_transaction(mode, idx, x, y, t);
	endtask

	task automatic eval_at(input int t);
		send_item(MODE_EVAL, IDX_W'($urandom), $urandom, $urandom, T_W'(t));
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (curve.pending() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_count(input logic [COUNT_W-1:0] v);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = v;
		@(posedge clk);
		curve.set_count(v);
		cfg_writes++;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic logic [COORD_W-1:0] rand_coord();
		case ($urandom_range(9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic int live_knots(logic [COUNT_W-1:0] c);
		if (c < 1) return 1;
		if (c > KNOTS) return KNOTS;
		return int'(c);
	endfunction

	initial begin
		logic [COUNT_W-1:0] fixed_counts [7];
		logic [COUNT_W-1:0] cnt;
		int                 n;
		int                 pick;
		fixed_counts = '{7'd2, 7'd127, 7'd0, 7'd65, 7'd64, 7'd1, 7'd3};

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < KNOTS; i++)
			send_item(MODE_WRITE, IDX_W'(i), rand_coord(), rand_coord(), T_W'($urandom));

		eval_at(0);
		eval_at(65536);
		eval_at(-1);
		eval_at(65537);
		wait_for_results();
		write_count(7'd64);
		send_item(MODE_WRITE, 6'd0, 32'h8000_0000, 32'h7FFF_FFFF, T_W'($urandom));
		send_item(MODE_WRITE, 6'd1, 32'h7FFF_FFFF, 32'h8000_0000, T_W'($urandom));
		eval_at(1);
		eval_at(1040);
		eval_at(0);
		send_item(MODE_WRITE, 6'd63, 32'h7FFF_FFFF, 32'h8000_0000, T_W'($urandom));
		eval_at(65536);
		send_item(MODE_WRITE, 6'd62, 32'h8000_0000, 32'h7FFF_FFFF, T_W'($urandom));
		eval_at(65535);
		eval_at(32768);
		eval_at(-131072);
		eval_at(131071);
		eval_at(65537);
		wait_for_results();

		for (int p = 0; p < PHASES; p++) begin
			if (p < 4) begin
				src_idle_pct  = 27;
				sink_idle_pct = 48;
			end else if (p < 8) begin
				src_idle_pct  = 48;
				sink_idle_pct = 27;
			end else begin
				src_idle_pct  = 0;
				sink_idle_pct = 0;
			end
			cnt = (p < 7) ? fixed_counts[p] : COUNT_W'($urandom_range(127));
			write_count(cnt);
			n = live_knots(cnt);
			for (int i = 0; i < PER_PHASE; i++) begin
				if (p == 9 && i == PER_PHASE / 2)
					wait_for_results();
				pick = $urandom_range(99);
				if (pick < 20)
					send_item(MODE_WRITE, IDX_W'($urandom), rand_coord(), rand_coord(),
						T_W'($urandom));
				else if (pick < 32)
					eval_at(int'($urandom) % (1 << T_W));
				else if (pick < 42 && n > 1)
					eval_at(($urandom_range(n - 1) * 65536) / (n - 1));
				else
					eval_at($urandom_range(65536));
			end
			wait_for_results();
		end

		curve.close();
		$display("Ran %0d evaluations (%0d outside the domain) and %0d knot writes",
			curve.evals, curve.out_of_domain, curve.writes);
		$display("over %0d knot count settings; %0d points checked, %0d failures",
			cfg_writes, curve.points_checked, curve.failures);
		if (curve.failures == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Timeout waiting for the evaluator");
		$display("Verification failed");
		$finish;
	end

endmodule
